/* rtl/core/ttce_pkg.sv */
package ttce_pkg;

   // Field widths of the channels
   localparam int POS_W       = 12;
   localparam int CMD_W       = 3;
   localparam int GLYPH_W     = 8;
   localparam int MODE_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   // Depth of the job queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   // Drawing commands
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR_SCREEN = 3'd0,
      CMD_CLEAR_CELL   = 3'd1,
      CMD_DRAW_GLYPH   = 3'd2,
      CMD_INVERT_CELL  = 3'd3,
      CMD_SHOW         = 3'd4
   } command_type;

   // Input item kinds
   localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_SCALE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y      = 3'd4;

   // Character codes
   localparam logic [CHAR_W-1:0] KEY_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] KEY_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] KEY_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] KEY_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] KEY_ESC   = 8'h1B;
   localparam logic [CHAR_W-1:0] KEY_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] KEY_UP_E  = 8'h45;
   localparam logic [CHAR_W-1:0] KEY_LO_E  = 8'h65;
   localparam logic [CHAR_W-1:0] KEY_LO_F  = 8'h66;
   localparam logic [CHAR_W-1:0] KEY_LO_V  = 8'h76;
   localparam logic [CHAR_W-1:0] KEY_LO_W  = 8'h77;

   // Cell size multipliers
   localparam logic [5:0] CELL_W_MUL = 6'd6;
   localparam logic [5:0] CELL_H_MUL = 6'd9;

   // Cursor state
   typedef enum logic [1:0] {
      CUR_OFF   = 2'd0,
      CUR_ON    = 2'd1,
      CUR_DRAWN = 2'd2
   } cursor_type;

   // One job: the one or two commands caused by one input item
   typedef struct packed {
      command_type          first_cmd;
      command_type          second_cmd;
      logic                 two_cmds;
      logic [POS_W-1:0]     pos_x;
      logic [POS_W-1:0]     pos_y;
      logic [GLYPH_W-1:0]   glyph;
   } job_type;

   // Back-end sequencer phase
   typedef enum logic {
      SEQ_FIRST  = 1'b0,
      SEQ_SECOND = 1'b1
   } seq_state_type;

endpackage

/* rtl/core/ttce_front.sv */
module ttce_front import ttce_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_push,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [CHAR_W-1:0]      req_char_code,
   input  logic                   q_full,
   output logic                   job_push,
   output job_type                job
);

   // Extended width for coordinate math: holds a coordinate plus a cell step
   localparam int EW = (COORD_BITS + 1 > POS_W) ? COORD_BITS + 1 : POS_W;
   localparam logic [EW-1:0] COORD_MAX = EW'((64'd1 << COORD_BITS) - 64'd1);

   // Configuration registers
   logic [2:0]  scale_ff;
   logic [10:0] width_ff;
   logic [10:0] height_ff;
   logic [9:0]  org_x_ff;
   logic [9:0]  org_y_ff;

   // Terminal state
   logic                  esc_ff,    esc_in;
   logic                  wrap_ff,   wrap_in;
   cursor_type            cursor_ff, cursor_in;
   logic [COORD_BITS-1:0] col_ff,    col_in;
   logic [COORD_BITS-1:0] row_ff,    row_in;

   logic [5:0]    cw;
   logic [5:0]    chh;
   logic [EW-1:0] col_x, row_x, cw_x, chh_x, width_x, height_x;
   logic [EW-1:0] org_x_sat, org_y_sat;
   logic [EW-1:0] col_end, col_adv, org_adv, row_down, col_back, bs_limit;
   logic [EW-1:0] col1, row1, col_print_next;
   logic          wrapped, fits, bs_ok;
   logic          accept, run_byte;
   logic [CHAR_W-1:0] byte_v;

   function automatic logic [EW-1:0] sat(input logic [EW-1:0] v);
      sat = (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   // Cell geometry
   assign cw       = {3'b000, scale_ff} * CELL_W_MUL;
   assign chh      = {3'b000, scale_ff} * CELL_H_MUL;
   assign col_x    = EW'(col_ff);
   assign row_x    = EW'(row_ff);
   assign cw_x     = EW'(cw);
   assign chh_x    = EW'(chh);
   assign width_x  = EW'(width_ff);
   assign height_x = EW'(height_ff);
   assign org_x_sat = sat(EW'(org_x_ff));
   assign org_y_sat = sat(EW'(org_y_ff));

   // Candidate positions, all computed side by side
   assign col_end  = col_x + cw_x;
   assign col_adv  = sat(col_end);
   assign org_adv  = sat(org_x_sat + cw_x);
   assign row_down = sat(row_x + chh_x);
   assign bs_limit = EW'(org_x_ff) + cw_x;
   assign bs_ok    = col_x >= bs_limit;
   assign col_back = col_x - cw_x;

   // Forward wrap and clipping
   assign wrapped = wrap_ff && (col_end > width_x);
   assign col1    = wrapped ? org_x_sat : col_x;
   assign row1    = wrapped ? row_down : row_x;
   assign fits    = wrapped ? ((org_x_sat < width_x) && (row_down < height_x))
                            : ((col_x < width_x) && (row_x < height_x));
   assign col_print_next = wrapped ? org_adv : col_adv;

   assign accept   = req_push && !q_full;
   assign run_byte = (req_mode == MODE_CHAR) ||
                     ((req_mode == MODE_END) && (cursor_ff != CUR_OFF));
   assign byte_v   = (req_mode == MODE_CHAR) ? req_char_code : KEY_NUL;

   // Item decode: next state and the job for the back end
   always_comb begin
      esc_in         = esc_ff;
      wrap_in        = wrap_ff;
      cursor_in      = cursor_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      job_push       = 1'b0;
      job.first_cmd  = CMD_CLEAR_CELL;
      job.second_cmd = CMD_DRAW_GLYPH;
      job.two_cmds   = 1'b0;
      job.pos_x      = col1[POS_W-1:0];
      job.pos_y      = row1[POS_W-1:0];
      job.glyph      = byte_v;
      if (accept) begin
         if (req_mode == MODE_BEGIN) begin
            if (cursor_ff == CUR_DRAWN) begin
               job_push      = 1'b1;
               job.first_cmd = CMD_INVERT_CELL;
               job.pos_x     = col_x[POS_W-1:0];
               job.pos_y     = row_x[POS_W-1:0];
               cursor_in     = CUR_ON;
            end
         end else if (run_byte) begin
            priority if (esc_ff) begin
               esc_in = 1'b0;
               priority if (byte_v == KEY_UP_E) begin
                  job_push      = 1'b1;
                  job.first_cmd = CMD_CLEAR_SCREEN;
                  col_in        = org_x_sat[COORD_BITS-1:0];
                  row_in        = org_y_sat[COORD_BITS-1:0];
               end else if (byte_v == KEY_LO_E) begin
                  if (cursor_ff == CUR_OFF) cursor_in = CUR_ON;
               end else if (byte_v == KEY_LO_F) begin
                  if (cursor_ff == CUR_ON) cursor_in = CUR_OFF;
               end else if (byte_v == KEY_LO_V) begin
                  wrap_in = 1'b1;
               end else if (byte_v == KEY_LO_W) begin
                  wrap_in = 1'b0;
               end else begin
                  esc_in = 1'b0;
               end
            end else if (byte_v == KEY_ESC) begin
               esc_in = 1'b1;
            end else if ((byte_v >= KEY_SPACE) || (byte_v == KEY_NUL)) begin
               col_in = col1[COORD_BITS-1:0];
               row_in = row1[COORD_BITS-1:0];
               if (fits) begin
                  job_push = 1'b1;
                  if (byte_v == KEY_NUL) begin
                     job.first_cmd  = CMD_INVERT_CELL;
                     job.second_cmd = CMD_SHOW;
                     job.two_cmds   = 1'b1;
                     cursor_in      = CUR_DRAWN;
                  end else begin
                     // space only clears; other glyphs clear then draw
                     job.two_cmds = (byte_v != KEY_SPACE);
                     col_in       = col_print_next[COORD_BITS-1:0];
                  end
               end
            end else if (byte_v == KEY_BS) begin
               if (bs_ok) col_in = col_back[COORD_BITS-1:0];
            end else if (byte_v == KEY_CR) begin
               col_in = org_x_sat[COORD_BITS-1:0];
            end else if (byte_v == KEY_LF) begin
               job_push      = 1'b1;
               job.first_cmd = CMD_SHOW;
               row_in        = row_down[COORD_BITS-1:0];
            end else begin
               esc_in = 1'b0;
            end
         end
      end
   end

   // State and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= 3'd1;
         width_ff  <= 11'd128;
         height_ff <= 11'd64;
         org_x_ff  <= 10'd0;
         org_y_ff  <= 10'd0;
         esc_ff    <= 1'b0;
         wrap_ff   <= 1'b1;
         cursor_ff <= CUR_OFF;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         esc_ff    <= esc_in;
         wrap_ff   <= wrap_in;
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_CHAR_SCALE:    scale_ff  <= csr_data[2:0];
               CSR_SCREEN_WIDTH:  width_ff  <= csr_data;
               CSR_SCREEN_HEIGHT: height_ff <= csr_data;
               CSR_ORIGIN_X:      org_x_ff  <= csr_data[9:0];
               CSR_ORIGIN_Y:      org_y_ff  <= csr_data[9:0];
               default:           scale_ff  <= scale_ff;
            endcase
         end
      end
   end

   // A job is only written into a queue with room
   assert property (@(posedge clock) disable iff (reset) job_push |-> !q_full)
      else $error("front pushed a job into a full queue");

   // Any byte after ESC ends the escape
   assert property (@(posedge clock) disable iff (reset)
      (accept && esc_ff && (req_mode == MODE_CHAR)) |=> !esc_ff)
      else $error("escape not terminated");

endmodule

/* rtl/core/ttce_queue.sv */
module ttce_queue import ttce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff,  count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_CNT)
      else $error("queue fill count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a transfer");

endmodule

/* rtl/core/ttce_back.sv */
module ttce_back import ttce_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  job_type            head_job,
   input  logic               job_valid,
   output logic               job_take,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CMD_W-1:0]   rsp_command,
   output logic [POS_W-1:0]   rsp_pos_x,
   output logic [POS_W-1:0]   rsp_pos_y,
   output logic [GLYPH_W-1:0] rsp_glyph,
   output logic               rsp_last
);

   seq_state_type      seq_ff, seq_in;
   logic               out_valid_ff;
   command_type        cmd_ff;
   logic [POS_W-1:0]   pos_x_ff, pos_y_ff;
   logic [GLYPH_W-1:0] glyph_ff;
   logic               last_ff;

   logic               advance, load;
   command_type        sel_cmd;
   logic               sel_last;
   logic               has_pos;
   logic [POS_W-1:0]   sel_x, sel_y;
   logic [GLYPH_W-1:0] sel_glyph;

   assign advance = !out_valid_ff || rsp_pop;
   assign load    = advance && job_valid;

   // Next phase
   always_comb begin
      seq_in = seq_ff;
      if (load) begin
         unique case (seq_ff)
            SEQ_FIRST:  seq_in = head_job.two_cmds ? SEQ_SECOND : SEQ_FIRST;
            SEQ_SECOND: seq_in = SEQ_FIRST;
         endcase
      end
   end

   // Command selection for the output register
   always_comb begin
      sel_cmd   = (seq_ff == SEQ_SECOND) ? head_job.second_cmd : head_job.first_cmd;
      sel_last  = (seq_ff == SEQ_SECOND) || !head_job.two_cmds;
      job_take  = load && sel_last;
      has_pos   = (sel_cmd != CMD_CLEAR_SCREEN) && (sel_cmd != CMD_SHOW);
      sel_x     = has_pos ? head_job.pos_x : '0;
      sel_y     = has_pos ? head_job.pos_y : '0;
      sel_glyph = (sel_cmd == CMD_DRAW_GLYPH) ? head_job.glyph : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         if (advance) out_valid_ff <= job_valid;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff   <= sel_cmd;
         pos_x_ff <= sel_x;
         pos_y_ff <= sel_y;
         glyph_ff <= sel_glyph;
         last_ff  <= sel_last;
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_command = cmd_ff;
   assign rsp_pos_x   = pos_x_ff;
   assign rsp_pos_y   = pos_y_ff;
   assign rsp_glyph   = glyph_ff;
   assign rsp_last    = last_ff;

   // The job stays at the head while its second command is pending
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_SECOND) |-> job_valid)
      else $error("second command without a job");

   // The second command of a job always closes it
   assert property (@(posedge clock) disable iff (reset)
      (load && (seq_ff == SEQ_SECOND)) |=> (out_valid_ff && last_ff))
      else $error("second command not marked last");

endmodule

/* rtl/core/text_terminal_cursor_engine.sv */
// Terminal cursor engine: character stream in, drawing commands out.
// The first command of an item passes through the job queue and the output register to rsp.
// Throughput: one item per cycle accepted while req_full is low; the back end issues one
// command per cycle unless rsp stalls, so an item with two commands occupies it for both.
// Reset (synchronous, active high) restores registers, cursor and escape state, and
// empties the job queue and the output register.
module text_terminal_cursor_engine import ttce_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [CHAR_W-1:0]      req_char_code,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [CMD_W-1:0]       rsp_command,
   output logic [POS_W-1:0]       rsp_pos_x,
   output logic [POS_W-1:0]       rsp_pos_y,
   output logic [GLYPH_W-1:0]     rsp_glyph,
   output logic                   rsp_last
);

   logic    job_push, q_full, q_empty, job_take;
   job_type push_job, head_job;

   assign req_full = q_full;

   ttce_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_push      (req_push),
      .req_mode      (req_mode),
      .req_char_code (req_char_code),
      .q_full        (q_full),
      .job_push      (job_push),
      .job           (push_job)
   );

   ttce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (job_take),
      .head_job (head_job),
      .empty    (q_empty)
   );

   ttce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .job_valid   (!q_empty),
      .job_take    (job_take),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_command (rsp_command),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_glyph   (rsp_glyph),
      .rsp_last    (rsp_last)
   );

endmodule
